@@ design/gdr_pkg.sv @@
`default_nettype none
package gdr_pkg;
    localparam int MapBits  = 6;
    localparam int MapSide  = 1 << MapBits;
    localparam int MapDepth = MapSide * MapSide;
    localparam int FracBits = 16;
    localparam int MaxScreen = 1024;
    localparam int DistW = 2 * FracBits + 2;
    localparam logic [DistW-1:0] DistMax = (DistW'(1) << (2 * FracBits + 1)) - DistW'(1);
    // Side distances grow by at most MapSide + 1 deltas before the walk leaves the map.
    localparam int SideW = DistW + MapBits;

    localparam logic [2:0] RegWidth  = 3'd0;
    localparam logic [2:0] RegHeight = 3'd1;
    localparam logic [2:0] RegPosX   = 3'd2;
    localparam logic [2:0] RegPosY   = 3'd3;
    localparam logic [2:0] RegDirX   = 3'd4;
    localparam logic [2:0] RegDirY   = 3'd5;
    localparam logic [2:0] RegPlaneX = 3'd6;
    localparam logic [2:0] RegPlaneY = 3'd7;

    typedef struct packed {
        logic       mode;
        logic [9:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       cell_wall;
    } gdr_in_t;

    typedef struct packed {
        logic [9:0] out_column;
        logic [9:0] span_start;
        logic [9:0] span_end;
        logic       side_y;
    } gdr_out_t;

    typedef struct packed {
        logic                  start;
        logic [DistW+FracBits-1:0] num;
        logic [SideW-1:0]      den;
    } gdr_div_req_t;
endpackage
`default_nettype wire

@@ design/grid_dda_column_raycaster.sv @@
`default_nettype none
// Grid DDA column raycaster.
// Input channel s_*: an item with mode 0 writes one cell of the 64x64 wall
// bitmap and yields no result; an item with mode 1 casts one screen column
// and yields one result item on m_* carrying the wall span rows and the side.
// Configuration must be written through cfg_we/cfg_index/cfg_data while
// idle; the block itself does not enforce this. One item is worked at a
// time. A cast runs up to four restoring divisions on one shared divider
// (camera coordinate, two ray deltas, the span height); a zero ray
// component or a zero distance skips its division. Three steps sit between
// them, and the grid walk reads the bitmap memory for each cell crossed,
// but not for the step that leaves the map. The next item can be taken in
// the cycle after the result of a cast is loaded. After reset a sweep
// clears the bitmap; no item is accepted during it. The result is held in
// an output register. When the receiver stalls, the block still accepts
// and works the next item, but that cast waits before its span stage until
// the register is free, and the input stalls behind it.
module grid_dda_column_raycaster
    import gdr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire gdr_in_t   s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output gdr_out_t       m_data,
    input  wire logic      cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [21:0] cfg_data
);
    localparam int NW = DistW + FracBits;
    // The camera quotient stays below 2*MaxScreen*S even when the width clamps to one.
    localparam int CamW = FracBits + 12;
    localparam int ProdW = CamW + 18;
    localparam int RayW = ProdW - FracBits + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_WR    = 11'b00000000010,
        S_CAM   = 11'b00000000100,
        S_RAYM  = 11'b00000001000,
        S_RAY   = 11'b00000010000,
        S_DX    = 11'b00000100000,
        S_DY    = 11'b00001000000,
        S_SIDE  = 11'b00010000000,
        S_STEP  = 11'b00100000000,
        S_TEST  = 11'b01000000000,
        S_LINE  = 11'b10000000000
    } state_t;

    state_t state_reg;
    logic [10:0] width_reg, height_reg;
    logic [21:0] posx_reg, posy_reg;
    logic signed [17:0] dirx_reg, diry_reg, plx_reg, ply_reg;

    gdr_in_t item_reg;
    logic signed [CamW-1:0] cam_reg;
    logic signed [ProdW-1:0] px_reg, py_reg;
    logic signed [RayW-1:0] rayx_reg, rayy_reg;
    logic [DistW-1:0] dx_reg, dy_reg;
    logic [SideW-1:0] sx_reg, sy_reg;
    logic signed [MapBits+1:0] cx_reg, cy_reg;
    logic hside_reg, wait_reg;
    gdr_out_t out_reg;
    logic out_valid_reg;

    gdr_div_req_t dreq;
    logic ddone;
    logic [NW-1:0] dquot;
    logic map_we, map_rd, clearing;
    logic [10:0] w_cl, h_cl;
    logic [RayW-1:0] magx, magy;
    logic [ProdW-1:0] pxb, pyb;
    logic [FracBits-1:0] fx, fy;
    logic [SideW-1:0] perp;
    logic outside;
    logic out_free, out_load;

    function automatic logic [10:0] clamp_scr(input logic [10:0] v);
        if (v == '0) return 11'd1;
        if (v > 11'(MaxScreen)) return 11'(MaxScreen);
        return v;
    endfunction

    // floor(f*d/S) split into two narrow products
    function automatic logic [DistW-1:0] mul_frac(input logic [FracBits:0] f,
                                                  input logic [DistW-1:0] d);
        logic [DistW+FracBits:0] hi;
        logic [2*FracBits:0] lo;
        hi = {{FracBits{1'b0}}, d[DistW-1:FracBits]} * f;
        lo = d[FracBits-1:0] * f;
        return DistW'(hi + (lo >> FracBits));
    endfunction

    assign w_cl = clamp_scr(width_reg);
    assign h_cl = clamp_scr(height_reg);
    assign magx = rayx_reg[RayW-1] ? RayW'(-rayx_reg) : rayx_reg;
    assign magy = rayy_reg[RayW-1] ? RayW'(-rayy_reg) : rayy_reg;
    // Adding S-1 to a negative product makes the shift round toward zero.
    assign pxb = px_reg + {{(ProdW-FracBits){1'b0}}, {FracBits{px_reg[ProdW-1]}}};
    assign pyb = py_reg + {{(ProdW-FracBits){1'b0}}, {FracBits{py_reg[ProdW-1]}}};
    assign fx = posx_reg[FracBits-1:0];
    assign fy = posy_reg[FracBits-1:0];
    assign perp = hside_reg ? sy_reg - SideW'(dy_reg) : sx_reg - SideW'(dx_reg);
    assign outside = cx_reg < 0 || cy_reg < 0 || cx_reg >= MapSide || cy_reg >= MapSide;

    // The span stage only starts once the output register is free or being taken.
    assign out_free = !out_valid_reg || m_ready;
    assign out_load = (state_reg == S_LINE) &&
                      ((perp == '0) ? out_free : (wait_reg && ddone));

    assign s_ready = (state_reg == S_IDLE) && !clearing;
    assign map_we = (state_reg == S_WR);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    gdr_div u_div (.aclk, .aresetn, .req(dreq), .done(ddone), .quot(dquot));

    gdr_map u_map (
        .aclk, .aresetn,
        .we(map_we),
        .waddr({item_reg.cell_y, item_reg.cell_x}),
        .wdata(item_reg.cell_wall),
        .raddr({cy_reg[MapBits-1:0], cx_reg[MapBits-1:0]}),
        .rdata(map_rd),
        .clearing
    );

    always_comb begin
        dreq = '0;
        if (!wait_reg) begin
            case (state_reg)
                S_CAM: begin
                    dreq.start = 1'b1;
                    dreq.num = NW'({item_reg.column, 1'b0}) << FracBits;
                    dreq.den = SideW'(w_cl);
                end
                S_DX: if (magx != '0) begin
                    dreq.start = 1'b1;
                    dreq.num = NW'(1) << (2 * FracBits);
                    dreq.den = SideW'(magx);
                end
                S_DY: if (magy != '0) begin
                    dreq.start = 1'b1;
                    dreq.num = NW'(1) << (2 * FracBits);
                    dreq.den = SideW'(magy);
                end
                S_LINE: if (perp != '0 && out_free) begin
                    dreq.start = 1'b1;
                    dreq.num = NW'(h_cl) << FracBits;
                    dreq.den = perp;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 11'd640;
            height_reg <= 11'd480;
            posx_reg <= 22'd65536;
            posy_reg <= 22'd65536;
            dirx_reg <= 18'sd65536;
            diry_reg <= '0;
            plx_reg <= '0;
            ply_reg <= 18'sd43254;
        end else if (cfg_we) begin
            case (cfg_index)
                RegWidth:  width_reg <= cfg_data[10:0];
                RegHeight: height_reg <= cfg_data[10:0];
                RegPosX:   posx_reg <= cfg_data;
                RegPosY:   posy_reg <= cfg_data;
                RegDirX:   dirx_reg <= cfg_data[17:0];
                RegDirY:   diry_reg <= cfg_data[17:0];
                RegPlaneX: plx_reg <= cfg_data[17:0];
                RegPlaneY: ply_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        logic [NW-1:0] hl;
        logic [10:0] hh;
        logic [NW-1:0] e;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            wait_reg <= 1'b0;
        end else begin
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    item_reg <= s_data;
                    wait_reg <= 1'b0;
                    state_reg <= s_data.mode ? S_CAM : S_WR;
                end
                S_WR: state_reg <= S_IDLE;
                S_CAM: begin
                    if (!wait_reg) wait_reg <= 1'b1;
                    else if (ddone) begin
                        wait_reg <= 1'b0;
                        cam_reg <= $signed({1'b0, dquot[CamW-2:0]})
                                   - $signed(CamW'(1 << FracBits));
                        state_reg <= S_RAYM;
                    end
                end
                S_RAYM: begin
                    px_reg <= ProdW'(plx_reg * cam_reg);
                    py_reg <= ProdW'(ply_reg * cam_reg);
                    state_reg <= S_RAY;
                end
                S_RAY: begin
                    rayx_reg <= RayW'(dirx_reg) + RayW'($signed(pxb[ProdW-1:FracBits]));
                    rayy_reg <= RayW'(diry_reg) + RayW'($signed(pyb[ProdW-1:FracBits]));
                    state_reg <= S_DX;
                end
                S_DX: begin
                    if (magx == '0) begin
                        dx_reg <= DistMax;
                        state_reg <= S_DY;
                    end else if (!wait_reg) wait_reg <= 1'b1;
                    else if (ddone) begin
                        wait_reg <= 1'b0;
                        dx_reg <= DistW'(dquot);
                        state_reg <= S_DY;
                    end
                end
                S_DY: begin
                    if (magy == '0) begin
                        dy_reg <= DistMax;
                        state_reg <= S_SIDE;
                    end else if (!wait_reg) wait_reg <= 1'b1;
                    else if (ddone) begin
                        wait_reg <= 1'b0;
                        dy_reg <= DistW'(dquot);
                        state_reg <= S_SIDE;
                    end
                end
                S_SIDE: begin
                    sx_reg <= SideW'(mul_frac(rayx_reg[RayW-1] ? {1'b0, fx}
                                  : (FracBits+1)'(1 << FracBits) - {1'b0, fx}, dx_reg));
                    sy_reg <= SideW'(mul_frac(rayy_reg[RayW-1] ? {1'b0, fy}
                                  : (FracBits+1)'(1 << FracBits) - {1'b0, fy}, dy_reg));
                    cx_reg <= (MapBits+2)'(posx_reg[21:FracBits]);
                    cy_reg <= (MapBits+2)'(posy_reg[21:FracBits]);
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    if (sx_reg < sy_reg) begin
                        sx_reg <= sx_reg + SideW'(dx_reg);
                        cx_reg <= rayx_reg[RayW-1] ? cx_reg - 1'b1 : cx_reg + 1'b1;
                        hside_reg <= 1'b0;
                    end else begin
                        sy_reg <= sy_reg + SideW'(dy_reg);
                        cy_reg <= rayy_reg[RayW-1] ? cy_reg - 1'b1 : cy_reg + 1'b1;
                        hside_reg <= 1'b1;
                    end
                    wait_reg <= 1'b0;
                    state_reg <= S_TEST;
                end
                S_TEST: begin
                    // On entry the bitmap read is issued; once wait_reg is set the registered data is seen.
                    if (outside) state_reg <= S_LINE;
                    else if (!wait_reg) wait_reg <= 1'b1;
                    else begin
                        wait_reg <= 1'b0;
                        state_reg <= map_rd ? S_LINE : S_STEP;
                    end
                end
                S_LINE: begin
                    hh = h_cl >> 1;
                    if (perp == '0) begin
                        if (out_free) begin
                            out_reg <= {item_reg.column, 10'd0, 10'(h_cl - 11'd1), hside_reg};
                            state_reg <= S_IDLE;
                        end
                    end else if (!wait_reg) begin
                        if (out_free) wait_reg <= 1'b1;
                    end else if (ddone) begin
                        wait_reg <= 1'b0;
                        hl = dquot >> 1;
                        e = hl + NW'(hh);
                        out_reg.out_column <= item_reg.column;
                        out_reg.span_start <= (hl > NW'(hh)) ? 10'd0 : 10'(NW'(hh) - hl);
                        out_reg.span_end <= (e >= NW'(h_cl)) ? 10'(h_cl - 11'd1) : 10'(e);
                        out_reg.side_y <= hside_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/gdr_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module gdr_div
    import gdr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire gdr_div_req_t     req,
    output logic                  done,
    output logic [DistW+FracBits-1:0] quot
);
    localparam int NW = DistW + FracBits;
    logic [NW-1:0]     num_reg;
    logic [SideW:0]    rem_reg;
    logic [SideW-1:0]  den_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic [SideW:0]    trial;

    assign trial = {rem_reg[SideW-1:0], num_reg[NW-1]} - {1'b0, den_reg};
    assign quot = num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                num_reg <= req.num;
                den_reg <= req.den;
                rem_reg <= '0;
                cnt_reg <= 6'(NW - 1);
            end else if (busy_reg) begin
                if (!trial[SideW]) begin
                    rem_reg <= trial;
                    num_reg <= {num_reg[NW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[SideW-1:0], num_reg[NW-1]};
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/gdr_map.sv @@
`default_nettype none
// Wall bitmap with a clearing sweep after reset.
module gdr_map
    import gdr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  we,
    input  wire logic [2*MapBits-1:0]  waddr,
    input  wire logic                  wdata,
    input  wire logic [2*MapBits-1:0]  raddr,
    output logic                       rdata,
    output logic                       clearing
);
    logic                   mem [MapDepth];
    logic [2*MapBits:0]     clr_reg;

    assign clearing = !clr_reg[2*MapBits];

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (clearing) clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (clearing) mem[clr_reg[2*MapBits-1:0]] <= 1'b0;
        else if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ bench/grid_dda_column_raycaster_tb.sv @@
`timescale 1ns / 1ps

module grid_dda_column_raycaster_tb;
    import gdr_pkg::*;

    localparam logic ModeWrite = 1'b0;
    localparam logic ModeCast  = 1'b1;
    localparam longint Scale   = 65536;
    localparam longint LongDist = 64'h1_FFFF_FFFF;
    localparam int CycleLimit  = 4_000_000;
    localparam int HoldCycles  = 1500;

    // Scoreboard: a cycle-free model of the raycaster plus the queue of spans
    // it expects to see, oldest first.
    class span_scoreboard;
        bit            walls [MapDepth];
        int unsigned   scr_w, scr_h;
        longint        pos_x, pos_y, dir_x, dir_y, pln_x, pln_y;
        gdr_out_t      spans_due [$];
        int            errors;
        int            seen;

        function new();
            foreach (walls[i]) walls[i] = 1'b0;
            scr_w = 640; scr_h = 480;
            pos_x = Scale; pos_y = Scale;
            dir_x = Scale; dir_y = 0; pln_x = 0; pln_y = 43254;
            errors = 0; seen = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void set_reg(input logic [2:0] idx, input logic [21:0] d);
            case (idx)
                RegWidth:  scr_w = d[10:0];
                RegHeight: scr_h = d[10:0];
                RegPosX:   pos_x = d;
                RegPosY:   pos_y = d;
                RegDirX:   dir_x = $signed(d[17:0]);
                RegDirY:   dir_y = $signed(d[17:0]);
                RegPlaneX: pln_x = $signed(d[17:0]);
                RegPlaneY: pln_y = $signed(d[17:0]);
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(input int unsigned v);
            if (v < 1) return 1;
            if (v > MaxScreen) return MaxScreen;
            return v;
        endfunction

        // Fractional multiply f*d/S done in two halves so nothing overflows.
        function longint frac_mul(input longint f, input longint d);
            return f * (d >> FracBits) + ((f * (d & (Scale - 1))) >> FracBits);
        endfunction

        function void axis_start(input longint ray, input longint pos,
                                 output longint dl, output longint sd,
                                 output longint st);
            longint fr, mag;
            fr  = pos & (Scale - 1);
            mag = (ray < 0) ? -ray : ray;
            dl  = (mag == 0) ? LongDist : ((64'd1 << (2 * FracBits)) / mag);
            if (ray < 0) begin
                st = -1;
                sd = frac_mul(fr, dl);
            end else begin
                st = 1;
                sd = frac_mul(Scale - fr, dl);
            end
        endfunction

        function void note_input(input gdr_in_t it);
            longint w, h, cam, rx, ry, dlx, dly, sdx, sdy, stx, sty;
            longint cx, cy, perp, line_h, half_l, half_h, s, e;
            bit hit, side;
            gdr_out_t r;
            if (it.mode == ModeWrite) begin
                walls[{it.cell_y, it.cell_x}] = it.cell_wall;
                return;
            end
            w = clamp_dim(scr_w);
            h = clamp_dim(scr_h);
            cam = ((longint'(2) * it.column) << FracBits) / w - Scale;
            rx = dir_x + (pln_x * cam) / Scale;
            ry = dir_y + (pln_y * cam) / Scale;
            axis_start(rx, pos_x, dlx, sdx, stx);
            axis_start(ry, pos_y, dly, sdy, sty);
            cx = pos_x >> FracBits;
            cy = pos_y >> FracBits;
            hit = 1'b0;
            side = 1'b0;
            while (!hit) begin
                if (sdx < sdy) begin
                    sdx += dlx; cx += stx; side = 1'b0;
                end else begin
                    sdy += dly; cy += sty; side = 1'b1;
                end
                // Anything past the map edge is solid, so the walk always ends.
                if (cx < 0 || cy < 0 || cx >= MapSide || cy >= MapSide) hit = 1'b1;
                else hit = walls[cy * MapSide + cx];
            end
            perp = side ? sdy - dly : sdx - dlx;
            if (perp == 0) begin
                s = 0;
                e = h - 1;
            end else begin
                line_h = (h << FracBits) / perp;
                half_l = line_h / 2;
                half_h = h / 2;
                s = (half_l > half_h) ? 0 : half_h - half_l;
                e = half_l + half_h;
                if (e >= h) e = h - 1;
            end
            r.out_column = it.column;
            r.span_start = s[9:0];
            r.span_end   = e[9:0];
            r.side_y     = side;
            spans_due.push_back(r);
        endfunction

        task check(input gdr_out_t got);
            gdr_out_t want;
            seen++;
            if (spans_due.size() == 0) begin
                report($sformatf("unexpected result for column %0d", got.out_column));
                return;
            end
            want = spans_due.pop_front();
            if (got.out_column !== want.out_column)
                report($sformatf("column got %0d want %0d", got.out_column,
                                 want.out_column));
            if (got.span_start !== want.span_start)
                report($sformatf("col %0d start got %0d want %0d", want.out_column,
                                 got.span_start, want.span_start));
            if (got.span_end !== want.span_end)
                report($sformatf("col %0d end got %0d want %0d", want.out_column,
                                 got.span_end, want.span_end));
            if (got.side_y !== want.side_y)
                report($sformatf("col %0d side got %0d want %0d", want.out_column,
                                 got.side_y, want.side_y));
        endtask

        function int pending();
            return spans_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    gdr_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    gdr_out_t    m_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [21:0] cfg_data;

    grid_dda_column_raycaster dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    span_scoreboard sb = new();

    // Shared knobs between the sender and the receiver. When calm is set,
    // neither side inserts idle cycles. A hold request makes the receiver
    // refuse results for a long stretch so the block backs up.
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  cycles = 0;
    int  casts_sent = 0;
    int  writes_sent = 0;
    int  phases_run = 0;

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver. The result is checked at the edge where it is taken, then
    // m_ready is chosen for the next cycle: a long hold-off when asked,
    // otherwise a stall roughly one cycle in five unless the run is calm.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) sb.check(m_data);
            if (hold_req && hold_left == 0) begin
                hold_left <= HoldCycles;
                hold_req = 1'b0;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= (hold_left == 1);
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

    // One register write; the caller drops the write enable after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [21:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        sb.set_reg(idx, d);
    endtask

    // Full register set; only ever called with the block idle.
    task automatic load_view(input logic [10:0] w, input logic [10:0] h,
                             input logic [21:0] px, input logic [21:0] py,
                             input logic [17:0] dx, input logic [17:0] dy,
                             input logic [17:0] plx, input logic [17:0] ply);
        write_reg(RegWidth, 22'(w));
        write_reg(RegHeight, 22'(h));
        write_reg(RegPosX, px);
        write_reg(RegPosY, py);
        write_reg(RegDirX, 22'(dx));
        write_reg(RegDirY, 22'(dy));
        write_reg(RegPlaneX, 22'(plx));
        write_reg(RegPlaneY, 22'(ply));
        cfg_we <= 1'b0;
    endtask

    // Offer one item and hold it until it is taken. An optional idle gap
    // comes first; valid is only lowered when such a gap is inserted, so it
    // never drops and rises within one edge.
    task automatic send_item(input gdr_in_t it);
        if (!calm && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        if (it.mode == ModeCast) casts_sent++;
        else writes_sent++;
    endtask

    task automatic put_cell(input int x, input int y, input bit wall);
        gdr_in_t it;
        it = gdr_in_t'($urandom);
        it.mode = ModeWrite;
        it.cell_x = x[5:0];
        it.cell_y = y[5:0];
        it.cell_wall = wall;
        send_item(it);
    endtask

    task automatic cast_col(input int col);
        gdr_in_t it;
        it = gdr_in_t'($urandom);
        it.mode = ModeCast;
        it.column = col[9:0];
        send_item(it);
    endtask

    // Let everything drain before touching the registers. A cell write makes
    // no result, so a few extra cycles cover one still in flight.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        phases_run++;
    endtask

    // Random traffic under a random view. Most items are casts; the writes
    // keep reshaping the map, mostly opening it so walks go a fair way.
    task automatic random_phase(input int count, input int hold_at, input int drain_at);
        gdr_in_t it;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            if (i == drain_at) begin
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
            end
            it = gdr_in_t'($urandom);
            it.mode = ($urandom_range(99) < 70) ? ModeCast : ModeWrite;
            if (it.mode == ModeWrite) it.cell_wall = ($urandom_range(2) == 0);
            send_item(it);
        end
    endtask

    function automatic logic [10:0] pick_dim();
        case ($urandom_range(9))
            0: return 11'd0;
            1: return 11'h7FF;
            2: return 11'd1;
            default: return 11'($urandom_range(1, MaxScreen));
        endcase
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = RegWidth;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset view, a small room, edge columns.
        load_view(11'd640, 11'd480, 22'h10000, 22'h10000, 18'h10000, 18'h0,
                  18'h0, 18'd43254);
        put_cell(4, 1, 1'b1);
        put_cell(63, 63, 1'b1);
        put_cell(0, 0, 1'b1);
        put_cell(0, 0, 1'b0);
        cast_col(0);
        cast_col(320);
        cast_col(639);
        cast_col(1023);
        settle();

        // A ray with both components zero takes the longest delta on each axis.
        load_view(11'd640, 11'd480, 22'h20000, 22'h28000, 18'h0, 18'h0,
                  18'h0, 18'h0);
        cast_col(5);
        settle();

        // Standing on a grid line right next to a wall gives zero distance,
        // so the span must fill the whole height.
        load_view(11'd64, 11'd1024, 22'h0A0000, 22'h0A0000, 18'h30000, 18'h0,
                  18'h0, 18'h0);
        put_cell(9, 10, 1'b1);
        cast_col(0);
        settle();

        // Out-of-range screen sizes and the extreme register codes.
        load_view(11'd0, 11'd0, 22'h0, 22'h3FFFFF, 18'h1FFFF, 18'h20000,
                  18'h20000, 18'h1FFFF);
        cast_col(0);
        cast_col(1023);
        settle();
        load_view(11'h7FF, 11'h7FF, 22'h3FFFFF, 22'h0, 18'h20000, 18'h1FFFF,
                  18'h1FFFF, 18'h20000);
        cast_col(0);
        cast_col(700);
        cast_col(1023);
        settle();

        // Random phases under random views. One phase runs with no idling,
        // one backs the block up with a long receiver hold-off, and one
        // stops the sender until every result is home.
        for (int p = 0; p < 8; p++) begin
            load_view(pick_dim(), pick_dim(), 22'($urandom), 22'($urandom),
                      18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
            calm = (p == 3);
            random_phase(150, (p == 1) ? 40 : -1, (p == 2) ? 75 : -1);
            calm = 1'b0;
            settle();
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);

        $display("Covered %0d casts and %0d cell writes over %0d views; %0d spans checked.",
                 casts_sent, writes_sent, phases_run, sb.seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d spans never arrived", sb.errors, sb.pending());
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/gdr_pkg.sv
design/gdr_div.sv
design/gdr_map.sv
design/grid_dda_column_raycaster.sv
bench/grid_dda_column_raycaster_tb.sv
